/* hw/rtl/pra_pkg.sv */
package pra_pkg;

  localparam int LEVEL_W = 16;
  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 4;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

  // request commands
  localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SET      = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd3;

  // merge modes; the unused code merges like the sum
  localparam logic [MODE_W-1:0] MODE_MIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MAX = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SUM = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MERGE_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_FLOOR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_CEILING = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_LEVEL   = 2'd3;

  // shared unit operations
  localparam int ALU_OP_W = 3;
  localparam logic [ALU_OP_W-1:0] ALU_HOLD = 3'd0;
  localparam logic [ALU_OP_W-1:0] ALU_LOAD = 3'd1;
  localparam logic [ALU_OP_W-1:0] ALU_MIN  = 3'd2;
  localparam logic [ALU_OP_W-1:0] ALU_MAX  = 3'd3;
  localparam logic [ALU_OP_W-1:0] ALU_SADD = 3'd4;

  typedef struct packed {
    logic [ALU_OP_W-1:0] op;
    logic [LEVEL_W-1:0]  operand;
  } alu_ctl_t;

endpackage

/* hw/rtl/performance_request_aggregator_top.sv */
// Channel   Direction  Handshake            Payload
// in_       request    in_valid / in_stall  in_cmd, in_slot, in_req_level
// out_      result     out_valid/out_stall  out_status, out_changed, out_current_out
// cfg_      write      cfg_we               cfg_index, cfg_wdata
//
// Register, release and a failed set or clear go straight to the hand-off into the output
// register. A good set or clear runs a scan of all NUM_SLOTS slots through the shared
// merge unit, two clamps (ceiling, then floor), update and hand-off. The next request is
// taken only once the block is back in idle.
// Reset (rst_n low, synchronous) clears all slot marks and loads current level 0.
// A result held by out_stall also holds the block in S_DONE; requests are taken only while idle.
module performance_request_aggregator_top #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pra_pkg::CMD_W-1:0]           in_cmd,
  input  logic [pra_pkg::SLOT_W-1:0]          in_slot,
  input  logic [pra_pkg::LEVEL_W-1:0]         in_req_level,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_status,
  output logic                                out_changed,
  output logic [pra_pkg::LEVEL_W-1:0]         out_current_out,
  // configuration
  input  logic                                cfg_we,
  input  logic [pra_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pra_pkg::LEVEL_W-1:0]         cfg_wdata
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_SLOTS);

  // sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN     = 3'd1;
  localparam logic [2:0] S_CLAMP_HI = 3'd2;
  localparam logic [2:0] S_CLAMP_LO = 3'd3;
  localparam logic [2:0] S_UPDATE   = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  localparam int LW = pra_pkg::LEVEL_W;

  // configuration registers
  logic [pra_pkg::MODE_W-1:0] mode_r;
  logic [LW-1:0]              floor_r;
  logic [LW-1:0]              ceil_r;

  // block state
  logic [2:0]           state_r, state_nxt;
  logic [NUM_SLOTS-1:0] slot_vld_r, slot_vld_nxt;
  logic [NUM_SLOTS-1:0] slot_en_r, slot_en_nxt;
  logic [LW-1:0]        current_r, current_nxt;
  logic [CNT_W-1:0]     scan_cnt_r, scan_cnt_nxt;
  logic [IDX_W-1:0]     prev_idx_r;

  // finished result, then the output register
  logic          res_status_r, res_status_nxt;
  logic          res_changed_r, res_changed_nxt;
  logic [LW-1:0] res_level_r, res_level_nxt;
  logic          out_valid_r;
  logic          out_status_r;
  logic          out_changed_r;
  logic [LW-1:0] out_level_r;

  logic              accept;
  logic              in_range;
  logic [IDX_W-1:0]  slot_idx;
  logic              out_free;

  logic              ram_we;
  logic [LW-1:0]     ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [LW-1:0]     ram_rdata;

  pra_pkg::alu_ctl_t alu_ctl;
  logic [LW-1:0]     acc;
  logic [pra_pkg::ALU_OP_W-1:0] scan_op;
  logic [LW-1:0]     init_val;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_range = (32'(in_slot) < NUM_SLOTS);
  assign slot_idx = IDX_W'(in_slot);
  assign out_free = !out_valid_r || !out_stall;

  // slot levels; write on register or set, read one slot per scan cycle
  assign ram_raddr = (scan_cnt_r < LAST_CNT) ? scan_cnt_r[IDX_W-1:0] : '0;

  pra_ram #(
    .WIDTH(LW),
    .DEPTH(NUM_SLOTS)
  ) u_level_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot_idx),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  pra_merge_unit u_merge (
    .clk(clk),
    .ctl(alu_ctl),
    .acc(acc)
  );

  // per-mode scan operation and accumulator start value
  always_comb begin
    unique case (mode_r)
      pra_pkg::MODE_MIN: begin
        scan_op  = pra_pkg::ALU_MIN;
        init_val = ceil_r;
      end
      pra_pkg::MODE_MAX: begin
        scan_op  = pra_pkg::ALU_MAX;
        init_val = floor_r;
      end
      default: begin
        scan_op  = pra_pkg::ALU_SADD;
        init_val = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    slot_vld_nxt    = slot_vld_r;
    slot_en_nxt     = slot_en_r;
    current_nxt     = current_r;
    scan_cnt_nxt    = scan_cnt_r;
    res_status_nxt  = res_status_r;
    res_changed_nxt = res_changed_r;
    res_level_nxt   = res_level_r;
    ram_we          = 1'b0;
    ram_wdata       = in_req_level;
    alu_ctl.op      = pra_pkg::ALU_HOLD;
    alu_ctl.operand = ram_rdata;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_status_nxt  = 1'b0;
          res_changed_nxt = 1'b0;
          res_level_nxt   = current_r;
          state_nxt       = S_DONE;
          unique case (in_cmd)
            pra_pkg::CMD_REGISTER: begin
              if (in_range) begin
                slot_vld_nxt[slot_idx] = 1'b1;
                slot_en_nxt[slot_idx]  = 1'b0;
                ram_we                 = 1'b1;
                ram_wdata              = current_r;
              end
            end
            pra_pkg::CMD_RELEASE: begin
              if (in_range) begin
                slot_vld_nxt[slot_idx] = 1'b0;
                slot_en_nxt[slot_idx]  = 1'b0;
              end
            end
            default: begin
              // set or clear
              if (!in_range || !slot_vld_r[slot_idx]) begin
                res_status_nxt = 1'b1;
              end else begin
                if (in_cmd == pra_pkg::CMD_SET) begin
                  slot_en_nxt[slot_idx] = 1'b1;
                  ram_we                = 1'b1;
                end else begin
                  slot_en_nxt[slot_idx] = 1'b0;
                end
                alu_ctl.op      = pra_pkg::ALU_LOAD;
                alu_ctl.operand = init_val;
                scan_cnt_nxt    = '0;
                state_nxt       = S_SCAN;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        // read data is registered: it arrives in the cycle after its address
        if (scan_cnt_r != '0 && slot_en_r[prev_idx_r]) begin
          alu_ctl.op = scan_op;
        end
        if (scan_cnt_r == LAST_CNT) begin
          state_nxt = S_CLAMP_HI;
        end else begin
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
      end
      S_CLAMP_HI: begin
        alu_ctl.op      = pra_pkg::ALU_MIN;
        alu_ctl.operand = ceil_r;
        state_nxt       = S_CLAMP_LO;
      end
      S_CLAMP_LO: begin
        // floor applied last, so it wins over the ceiling
        alu_ctl.op      = pra_pkg::ALU_MAX;
        alu_ctl.operand = floor_r;
        state_nxt       = S_UPDATE;
      end
      S_UPDATE: begin
        res_changed_nxt = (acc != current_r);
        res_level_nxt   = acc;
        current_nxt     = acc;
        state_nxt       = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // start write loads current level at once; user must send writes only while idle; unchecked
    if (cfg_we && cfg_index == pra_pkg::CFG_START_LEVEL) begin
      current_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_vld_r  <= '0;
      slot_en_r   <= '0;
      current_r   <= '0;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      mode_r      <= pra_pkg::MODE_MIN;
      floor_r     <= '0;
      ceil_r      <= pra_pkg::LEVEL_MAX;
    end else begin
      state_r    <= state_nxt;
      slot_vld_r <= slot_vld_nxt;
      slot_en_r  <= slot_en_nxt;
      current_r  <= current_nxt;
      scan_cnt_r <= scan_cnt_nxt;

      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      // the user must write only while idle; the block does not enforce it
      if (cfg_we) begin
        unique case (cfg_index)
          pra_pkg::CFG_MERGE_MODE:    mode_r  <= cfg_wdata[pra_pkg::MODE_W-1:0];
          pra_pkg::CFG_LEVEL_FLOOR:   floor_r <= cfg_wdata;
          pra_pkg::CFG_LEVEL_CEILING: ceil_r  <= cfg_wdata;
          default:                    ; // start level goes through current_nxt
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    prev_idx_r    <= scan_cnt_r[IDX_W-1:0];
    res_status_r  <= res_status_nxt;
    res_changed_r <= res_changed_nxt;
    res_level_r   <= res_level_nxt;
    if (state_r == S_DONE && out_free) begin
      out_status_r  <= res_status_r;
      out_changed_r <= res_changed_r;
      out_level_r   <= res_level_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_changed     = out_changed_r;
  assign out_current_out = out_level_r;

endmodule

/* hw/rtl/pra_ram.sv */
module pra_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/pra_merge_unit.sv */
module pra_merge_unit (
  input  logic                              clk,
  input  pra_pkg::alu_ctl_t                 ctl,
  output logic [pra_pkg::LEVEL_W-1:0]       acc
);

  logic [pra_pkg::LEVEL_W-1:0] acc_r;
  logic [pra_pkg::LEVEL_W-1:0] acc_nxt;
  logic [pra_pkg::LEVEL_W:0]   sum;

  assign sum = {1'b0, acc_r} + {1'b0, ctl.operand};

  always_comb begin
    unique case (ctl.op)
      pra_pkg::ALU_LOAD: acc_nxt = ctl.operand;
      pra_pkg::ALU_MIN:  acc_nxt = (ctl.operand < acc_r) ? ctl.operand : acc_r;
      pra_pkg::ALU_MAX:  acc_nxt = (ctl.operand > acc_r) ? ctl.operand : acc_r;
      // saturate at full scale
      pra_pkg::ALU_SADD: acc_nxt = sum[pra_pkg::LEVEL_W] ? pra_pkg::LEVEL_MAX
                                                         : sum[pra_pkg::LEVEL_W-1:0];
      default:           acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

/* verif/pra_checker.sv */
`timescale 1ns / 1ps

module pra_checker #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [pra_pkg::CMD_W-1:0]     in_cmd,
  input  logic [pra_pkg::SLOT_W-1:0]    in_slot,
  input  logic [pra_pkg::LEVEL_W-1:0]   in_req_level,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_status,
  input  logic                          out_changed,
  input  logic [pra_pkg::LEVEL_W-1:0]   out_current_out,
  input  logic                          cfg_we,
  input  logic [pra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pra_pkg::LEVEL_W-1:0]   cfg_wdata,
  output int                            fail_count,
  output int                            pending,
  output int                            result_count
);
  import pra_pkg::*;

  typedef struct packed {
    logic               status;
    logic               changed;
    logic [LEVEL_W-1:0] level;
  } agg_result_t;

  agg_result_t        expected_q[$];
  logic [MODE_W-1:0]  mode_q;
  logic [LEVEL_W-1:0] floor_q;
  logic [LEVEL_W-1:0] ceil_q;
  logic [LEVEL_W-1:0] level_q;
  logic               slot_reg [NUM_SLOTS];
  logic               slot_on  [NUM_SLOTS];
  logic [LEVEL_W-1:0] slot_lvl [NUM_SLOTS];

  initial begin
    fail_count   = 0;
    pending      = 0;
    result_count = 0;
  end

  // merge of the enabled levels, then ceiling, then floor (floor wins)
  function automatic logic [LEVEL_W-1:0] merged_level();
    logic [LEVEL_W:0] acc;
    if (mode_q == MODE_MIN) begin
      acc = {1'b0, ceil_q};
      for (int i = 0; i < NUM_SLOTS; i++)
        if (slot_on[i] && slot_lvl[i] < acc) acc = {1'b0, slot_lvl[i]};
    end else if (mode_q == MODE_MAX) begin
      acc = {1'b0, floor_q};
      for (int i = 0; i < NUM_SLOTS; i++)
        if (slot_on[i] && slot_lvl[i] > acc) acc = {1'b0, slot_lvl[i]};
    end else begin
      // sum; the unused code lands here too
      acc = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_on[i]) begin
          acc = acc + slot_lvl[i];
          if (acc > LEVEL_MAX) acc = {1'b0, LEVEL_MAX};
        end
      end
    end
    if (acc > ceil_q) acc = {1'b0, ceil_q};
    if (acc < floor_q) acc = {1'b0, floor_q};
    return acc[LEVEL_W-1:0];
  endfunction

  function automatic agg_result_t apply_request(logic [CMD_W-1:0] cmd,
                                                logic [SLOT_W-1:0] slot,
                                                logic [LEVEL_W-1:0] lvl);
    agg_result_t        r;
    logic [LEVEL_W-1:0] m;
    logic               in_range;
    r.status  = 1'b0;
    r.changed = 1'b0;
    in_range  = (int'(slot) < NUM_SLOTS);
    case (cmd)
      CMD_REGISTER: begin
        if (in_range) begin
          slot_reg[slot] = 1'b1;
          slot_on[slot]  = 1'b0;
          slot_lvl[slot] = level_q;
        end
      end
      CMD_RELEASE: begin
        if (in_range && slot_reg[slot]) begin
          slot_reg[slot] = 1'b0;
          slot_on[slot]  = 1'b0;
        end
      end
      default: begin
        if (!in_range || !slot_reg[slot]) begin
          r.status = 1'b1;
        end else begin
          if (cmd == CMD_SET) begin
            slot_lvl[slot] = lvl;
            slot_on[slot]  = 1'b1;
          end else begin
            slot_on[slot] = 1'b0;
          end
          m = merged_level();
          if (m != level_q) begin
            r.changed = 1'b1;
            level_q   = m;
          end
        end
      end
    endcase
    r.level = level_q;
    return r;
  endfunction

  task automatic note_mismatch(string what, agg_result_t exp_r, agg_result_t got_r);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] MISMATCH %s: expected status=%0d changed=%0d level=%h",
               $realtime, what, exp_r.status, exp_r.changed, exp_r.level);
      $display("  got status=%0d changed=%0d level=%h",
               got_r.status, got_r.changed, got_r.level);
    end
  endtask

  always @(posedge clk) begin
    agg_result_t got_r;
    agg_result_t exp_r;
    if (!rst_n) begin
      mode_q  = MODE_MIN;
      floor_q = '0;
      ceil_q  = LEVEL_MAX;
      level_q = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_reg[i] = 1'b0;
        slot_on[i]  = 1'b0;
        slot_lvl[i] = '0;
      end
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got_r = '{out_status, out_changed, out_current_out};
        result_count++;
        if (expected_q.size() == 0) begin
          note_mismatch("result with no request outstanding", '0, got_r);
        end else begin
          exp_r = expected_q.pop_front();
          if (got_r.status !== exp_r.status || got_r.changed !== exp_r.changed ||
              got_r.level !== exp_r.level)
            note_mismatch("result fields", exp_r, got_r);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MERGE_MODE:    mode_q  = cfg_wdata[MODE_W-1:0];
          CFG_LEVEL_FLOOR:   floor_q = cfg_wdata;
          CFG_LEVEL_CEILING: ceil_q  = cfg_wdata;
          CFG_START_LEVEL:   level_q = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_q.push_back(apply_request(in_cmd, in_slot, in_req_level));
    end
    pending = expected_q.size();
  end

endmodule

/* verif/tb_performance_request_aggregator_top.sv */
`timescale 1ns / 1ps

module tb_performance_request_aggregator_top;
  import pra_pkg::*;

  localparam int NUM_SLOTS        = 16;
  localparam int PHASES           = 8;
  localparam int PHASE_REQUESTS   = 229;  // about 1830 random requests overall
  localparam int LONG_HOLD_CYCLES = 300;  // long enough to back the block up
  localparam int SETTLE_CYCLES    = 40;   // > one full slot scan
  // the fourth mode code has no name in the package; it merges like the sum
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [CMD_W-1:0]     in_cmd;
  logic [SLOT_W-1:0]    in_slot;
  logic [LEVEL_W-1:0]   in_req_level;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_status;
  logic                 out_changed;
  logic [LEVEL_W-1:0]   out_current_out;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LEVEL_W-1:0]   cfg_wdata;

  int fail_count;
  int pending;
  int result_count;
  int requests_sent;

  // idling switches shared by the sender and the receiver process
  bit idle_on;
  bit hold_long;

  performance_request_aggregator_top #(
    .NUM_SLOTS(NUM_SLOTS)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_slot         (in_slot),
    .in_req_level    (in_req_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_changed     (out_changed),
    .out_current_out (out_current_out),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // watches both channels and the config port, predicts and compares
  pra_checker #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_slot         (in_slot),
    .in_req_level    (in_req_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_changed     (out_changed),
    .out_current_out (out_current_out),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .result_count    (result_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #(5_000_000);
    $display("Some tests failed");
    $finish;
  end

  // Receiver: short random stall bursts, plus one long hold on request so
  // the block fills and pushes back on the request channel.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_long = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one request and hold it until taken. Valid is left high on return
  // so back-to-back requests need no extra edge; a gap lowers it first.
  task automatic send_request(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                              logic [LEVEL_W-1:0] lvl);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_slot      <= slot;
    in_req_level <= lvl;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  // Stop offering and wait until every outstanding result is back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (4) @(posedge clk);
  endtask

  // Back-to-back register writes, block idle. Mode write carries junk in
  // the upper data bits, which must be ignored.
  task automatic program_regs(logic [MODE_W-1:0] mode, logic [LEVEL_W-1:0] flo,
                              logic [LEVEL_W-1:0] ceil, logic [LEVEL_W-1:0] start,
                              bit load_start);
    logic [LEVEL_W-MODE_W-1:0] pad;
    pad = (LEVEL_W-MODE_W)'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MERGE_MODE;
    cfg_wdata <= {pad, mode};
    @(posedge clk);
    cfg_index <= CFG_LEVEL_FLOOR;
    cfg_wdata <= flo;
    @(posedge clk);
    cfg_index <= CFG_LEVEL_CEILING;
    cfg_wdata <= ceil;
    @(posedge clk);
    if (load_start) begin
      cfg_index <= CFG_START_LEVEL;
      cfg_wdata <= start;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly set/clear on random slots; register and release
  // keep the table churning.
  function automatic logic [CMD_W-1:0] pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return CMD_REGISTER;
    if (r < 23) return CMD_RELEASE;
    if (r < 78) return CMD_SET;
    return CMD_CLEAR;
  endfunction

  // Extremes, small values (keep the sum off saturation), and full range.
  function automatic logic [LEVEL_W-1:0] pick_level();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return LEVEL_MAX;
    if (r < 5)  return LEVEL_W'($urandom_range(0, 255));
    if (r < 7)  return LEVEL_W'($urandom_range(0, 4095));
    return LEVEL_W'($urandom);
  endfunction

  initial begin
    logic [MODE_W-1:0]  mode;
    logic [LEVEL_W-1:0] flo;
    logic [LEVEL_W-1:0] ceil;
    logic [LEVEL_W-1:0] start;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_cmd        = CMD_REGISTER;
    in_slot       = '0;
    in_req_level  = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_MERGE_MODE;
    cfg_wdata     = '0;
    idle_on       = 1'b1;
    hold_long     = 1'b0;
    requests_sent = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed: reset defaults (min merge, floor 0, ceiling max) ---
    send_request(CMD_SET, 4'd0, 16'h1234);      // set on unregistered slot -> status 1
    send_request(CMD_CLEAR, 4'd1, 16'h0000);    // clear on unregistered slot -> status 1
    send_request(CMD_RELEASE, 4'd2, 16'hFFFF);  // release of unregistered slot, ignored
    send_request(CMD_REGISTER, 4'd0, 16'hFFFF); // loads current level, level field unused
    send_request(CMD_SET, 4'd0, 16'hFFFF);
    send_request(CMD_REGISTER, 4'd15, 16'h0000);
    send_request(CMD_SET, 4'd15, 16'h0000);     // min drops to zero
    send_request(CMD_SET, 4'd15, 16'h0000);     // same again: no change
    send_request(CMD_REGISTER, 4'd15, 16'h0000); // re-register reloads and disables
    send_request(CMD_CLEAR, 4'd0, 16'h0000);    // nothing enabled: min gives the ceiling
    send_request(CMD_RELEASE, 4'd0, 16'h0000);
    send_request(CMD_SET, 4'd0, 16'h0005);      // released slot -> status 1
    drain();

    // floor above ceiling: floor must win; start level loads current level
    program_regs(MODE_MAX, 16'h8000, 16'h1000, 16'h1234, 1'b1);
    send_request(CMD_REGISTER, 4'd3, 16'h0000);
    send_request(CMD_SET, 4'd3, 16'hFFFF);
    send_request(CMD_CLEAR, 4'd3, 16'h0000);
    drain();

    // saturating sum
    program_regs(MODE_SUM, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1);
    send_request(CMD_REGISTER, 4'd4, 16'h0000);
    send_request(CMD_REGISTER, 4'd5, 16'h0000);
    send_request(CMD_SET, 4'd4, 16'hC000);
    send_request(CMD_SET, 4'd5, 16'hC000);
    drain();

    // unused mode code behaves as the sum
    program_regs(MODE_UNUSED, 16'h0000, 16'hFFFF, 16'h0000, 1'b0);
    send_request(CMD_SET, 4'd4, 16'h0001);
    send_request(CMD_CLEAR, 4'd5, 16'h0000);
    drain();

    // --- random phases, each with its own register setting ---
    for (int p = 0; p < PHASES; p++) begin
      start = LEVEL_W'($urandom);
      case (p)
        0: begin mode = MODE_MIN; flo = '0; ceil = LEVEL_MAX; end
        1: begin mode = MODE_MAX; flo = '0; ceil = LEVEL_MAX; end
        2: begin mode = MODE_SUM; flo = '0; ceil = LEVEL_MAX; end
        3: begin
          mode  = MODE_UNUSED;
          flo   = LEVEL_W'($urandom_range(0, 255));
          ceil  = LEVEL_W'($urandom_range(16'hF000, 16'hFFFF));
          start = LEVEL_MAX;
        end
        4: begin
          // inverted limits
          mode = MODE_MIN;
          flo  = LEVEL_W'($urandom_range(16'h8000, 16'hFFFF));
          ceil = LEVEL_W'($urandom_range(0, 16'h7FFF));
        end
        5: begin
          mode = MODE_MAX;
          flo  = LEVEL_W'($urandom_range(0, 16'h3FFF));
          ceil = LEVEL_W'($urandom_range(16'hC000, 16'hFFFF));
        end
        6: begin
          // floor equals ceiling: result pinned
          mode = MODE_W'($urandom_range(0, 3));
          flo  = LEVEL_W'($urandom);
          ceil = flo;
        end
        default: begin
          mode = MODE_W'($urandom_range(0, 3));
          flo  = LEVEL_W'($urandom_range(0, 16'h0FFF));
          ceil = LEVEL_W'($urandom);
        end
      endcase
      program_regs(mode, flo, ceil, start, (p % 2 == 1) || (p == 3));

      if (p == PHASES - 1) idle_on = 1'b0;  // clean back-to-back stretch at the end
      if (p == 5) hold_long = 1'b1;         // receiver backs up, sender keeps pushing

      for (int n = 0; n < PHASE_REQUESTS; n++)
        send_request(pick_cmd(), SLOT_W'($urandom_range(0, NUM_SLOTS - 1)), pick_level());
      // sender pauses here until every outstanding result is back
      drain();
    end

    // everything back; let any stray output show up
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Coverage: %0d requests over min, max, sum and the unused mode code,",
             requests_sent);
    $display("  odd limits, start loads, a long output hold; %0d results checked.",
             result_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
